// ===== sv/mlp_dense_layer_inference_core_assert.svh =====
// assertion macros used by the checker file
// clocked on clk and disabled while arst_n is low
`ifndef MLP_DENSE_LAYER_INFERENCE_CORE_ASSERT_SVH
`define MLP_DENSE_LAYER_INFERENCE_CORE_ASSERT_SVH

// condition implies consequence in the same cycle
`define MLPDL_ASSERT_SAME(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define MLPDL_ASSERT_NEXT(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/mlpdl_pkg.sv =====
// ----------------------------------------------------------------------------
// mlpdl_pkg
// widths, constants and sigmoid table of the dense layer inference core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mlpdl_pkg;

	localparam int MAX_LAYERS     = 4;
	localparam int MAX_WIDTH      = 16;
	localparam int VALUE_BITS     = 16;
	localparam int FRAC_BITS      = 12;

	localparam int LAYER_BITS     = $clog2(MAX_LAYERS);
	localparam int ROW_BITS       = $clog2(MAX_WIDTH);
	localparam int CNT_BITS       = ROW_BITS + 1;
	localparam int W_DEPTH        = MAX_LAYERS * MAX_WIDTH * MAX_WIDTH;
	localparam int B_DEPTH        = MAX_LAYERS * MAX_WIDTH;
	localparam int ACC_BITS       = 2 * VALUE_BITS + ROW_BITS + 1;
	localparam int Z_BITS         = ACC_BITS - FRAC_BITS;
	localparam int CFG_DATA_BITS  = 5;
	localparam int CFG_INDEX_BITS = 3;
	localparam int LUT_DEPTH      = 256;
	localparam int LUT_FRAC       = 16;
	localparam int SIG_BITS       = FRAC_BITS + 1;

	localparam logic [31:0] EXP_STEP = 32'd4034748382;

	typedef logic [SIG_BITS-1:0] sig_lut_t [LUT_DEPTH];

	function automatic sig_lut_t build_sig_lut();
		sig_lut_t    t;
		logic [95:0] p;
		logic [63:0] d;
		logic [63:0] num;
		logic [63:0] rem;
		logic [63:0] s;
		logic [63:0] v;
		logic [63:0] r;
		int          n;
		int          i;
		t = '{default: '0};
		p = 96'd1 << 32;
		for (n = 0; n <= 128; n++) begin
			if (n == 1)
				p = 96'(EXP_STEP);
			else if (n > 1)
				p = (p * 96'(EXP_STEP) + (96'd1 << 31)) >> 32;
			d   = 64'(p) + (64'd1 << 32);
			num = (64'd1 << 48) + (d >> 1);
			rem = '0;
			s   = '0;
			for (i = 49; i >= 0; i--) begin
				rem = {rem[62:0], num[i]};
				if (rem >= d) begin
					rem  = rem - d;
					s[i] = 1'b1;
				end
			end
			if (n < 128) begin
				v = s;
				r = ((v << FRAC_BITS) + (64'd1 << (LUT_FRAC - 1))) >> LUT_FRAC;
				t[128 + n] = SIG_BITS'(r);
			end
			if (n > 0) begin
				v = 64'd65536 - s;
				r = ((v << FRAC_BITS) + (64'd1 << (LUT_FRAC - 1))) >> LUT_FRAC;
				t[128 - n] = SIG_BITS'(r);
			end
		end
		return t;
	endfunction

	localparam sig_lut_t SIG_LUT = build_sig_lut();

endpackage

// ===== sv/mlp_dense_layer_inference_core.sv =====
// ----------------------------------------------------------------------------
// mlp_dense_layer_inference_core
// dense multilayer perceptron inference, signed q4.12, one shared mac
// ----------------------------------------------------------------------------
// input channel: in_valid/in_stall carry action, layer_sel, row_sel,
// col_sel and value. weight, bias and input loads are taken only while idle.
// a start request runs every configured layer as y = act(w*x + b) and
// stalls the input until the last result has been taken.
// per layer and output row: a bias read, then for each input column a
// weight ram read, a multiply and an accumulate, then rounding and
// activation; the row results are moved once per layer.
// output channel: out_valid/out_stall carry out_index, out_value and
// out_last, one result per final-layer row; a stall holds the result.
// configuration through cfg_we/cfg_index/cfg_data, by the user only while
// idle; the block does not enforce this. reset: registers to defaults,
// biases and inputs to zero; weights must be written before they are used.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlp_dense_layer_inference_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [mlpdl_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [mlpdl_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [1:0]                             action,
	input  logic [mlpdl_pkg::LAYER_BITS-1:0]       layer_sel,
	input  logic [mlpdl_pkg::ROW_BITS-1:0]         row_sel,
	input  logic [mlpdl_pkg::ROW_BITS-1:0]         col_sel,
	input  logic signed [mlpdl_pkg::VALUE_BITS-1:0] value,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [mlpdl_pkg::ROW_BITS-1:0]         out_index,
	output logic signed [mlpdl_pkg::VALUE_BITS-1:0] out_value,
	output logic                                   out_last
);

	import mlpdl_pkg::*;

	localparam logic [1:0] ACT_WEIGHT = 2'd0;
	localparam logic [1:0] ACT_BIAS   = 2'd1;
	localparam logic [1:0] ACT_INPUT  = 2'd2;
	localparam logic [1:0] ACT_START  = 2'd3;

	localparam logic [CFG_INDEX_BITS-1:0] REG_LAYER_COUNT = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH_IN    = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH_FIRST = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH_LAST  = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ACT_MODE    = 3'd6;

	localparam int W_ADDR_BITS = $clog2(W_DEPTH);
	localparam int B_ADDR_BITS = $clog2(B_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE, S_BIAS, S_BLD, S_RD, S_MUL, S_ADD, S_RND, S_ACT, S_COPY, S_OUT
	} state_t;

	state_t                        state_q;
	logic [2:0]                    lcount_q;
	logic [CFG_DATA_BITS-1:0]      win_q;
	logic [CFG_DATA_BITS-1:0]      wout_q [MAX_LAYERS];
	logic                          relu_q;
	logic [LAYER_BITS-1:0]         layer_q;
	logic [ROW_BITS-1:0]           row_q;
	logic [ROW_BITS-1:0]           col_q;
	logic [B_DEPTH-1:0]            bias_vld_q;
	logic signed [VALUE_BITS-1:0]  in_q  [MAX_WIDTH];
	logic signed [VALUE_BITS-1:0]  hid_q [MAX_WIDTH];
	logic signed [VALUE_BITS-1:0]  tmp_q [MAX_WIDTH];
	logic signed [ACC_BITS-1:0]    acc_q;
	logic signed [2*VALUE_BITS-1:0] prod_q;
	logic signed [Z_BITS-1:0]      z_q;

	logic [CNT_BITS-1:0]           wout_c [MAX_LAYERS];
	logic [CNT_BITS-1:0]           win_c;
	logic [2:0]                    lcount_c;
	logic [CNT_BITS-1:0]           sel_ow;
	logic [CNT_BITS-1:0]           sel_iw;
	logic [CNT_BITS-1:0]           run_ow;
	logic [CNT_BITS-1:0]           run_iw;
	logic                          in_acc;
	logic                          w_we;
	logic                          b_we;
	logic                          x_we;
	logic [W_ADDR_BITS-1:0]        w_addr;
	logic [B_ADDR_BITS-1:0]        b_addr;
	logic [VALUE_BITS-1:0]         w_rdata;
	logic [VALUE_BITS-1:0]         b_rdata;
	logic signed [VALUE_BITS-1:0]  x_sel;
	logic signed [ACC_BITS-1:0]    acc_rnd;
	logic signed [Z_BITS-1:0]      qz;
	logic [7:0]                    lut_idx;
	logic [VALUE_BITS-1:0]         act_val;
	logic                          row_end;
	logic                          col_end;
	logic                          layer_end;
	logic                          out_acc;

	function automatic logic [CNT_BITS-1:0] clamp_w(logic [CFG_DATA_BITS-1:0] w);
		if (w == '0)
			return CNT_BITS'(1);
		if (CNT_BITS'(w) > CNT_BITS'(MAX_WIDTH))
			return CNT_BITS'(MAX_WIDTH);
		return CNT_BITS'(w);
	endfunction

	always_comb begin
		for (int l = 0; l < MAX_LAYERS; l++)
			wout_c[l] = clamp_w(wout_q[l]);
		win_c = clamp_w(win_q);
		if (lcount_q == '0)
			lcount_c = 3'd1;
		else if (lcount_q > 3'(MAX_LAYERS))
			lcount_c = 3'(MAX_LAYERS);
		else
			lcount_c = lcount_q;
	end

	assign sel_ow = wout_c[layer_sel];
	assign sel_iw = (layer_sel == '0) ? win_c : wout_c[layer_sel - 1'b1];
	assign run_ow = wout_c[layer_q];
	assign run_iw = (layer_q == '0) ? win_c : wout_c[layer_q - 1'b1];

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign w_we = in_acc && (action == ACT_WEIGHT) && ({1'b0, row_sel} < sel_ow)
		&& ({1'b0, col_sel} < sel_iw);
	assign b_we = in_acc && (action == ACT_BIAS) && ({1'b0, row_sel} < sel_ow);
	assign x_we = in_acc && (action == ACT_INPUT) && ({1'b0, row_sel} < win_c);

	assign w_addr = (state_q == S_IDLE) ? {layer_sel, row_sel, col_sel}
		: {layer_q, row_q, col_q};
	assign b_addr = (state_q == S_IDLE) ? {layer_sel, row_sel} : {layer_q, row_q};

	mlpdl_ram #(.WIDTH(VALUE_BITS), .DEPTH(W_DEPTH)) u_wram (
		.clk   (clk),
		.we    (w_we),
		.addr  (w_addr),
		.wdata (value),
		.rdata (w_rdata)
	);

	mlpdl_ram #(.WIDTH(VALUE_BITS), .DEPTH(B_DEPTH)) u_bram (
		.clk   (clk),
		.we    (b_we),
		.addr  (b_addr),
		.wdata (value),
		.rdata (b_rdata)
	);

	assign x_sel     = (layer_q == '0) ? in_q[col_q] : hid_q[col_q];
	assign col_end   = ({1'b0, col_q} + CNT_BITS'(1)) == run_iw;
	assign row_end   = ({1'b0, row_q} + CNT_BITS'(1)) == run_ow;
	assign layer_end = ({1'b0, layer_q} + 3'd1) == lcount_c;
	assign out_acc   = out_valid && !out_stall;

	// round half up, then floor shift
	assign acc_rnd = acc_q + (ACC_BITS'(1) << (FRAC_BITS - 1));

	always_comb begin
		logic signed [Z_BITS-1:0] qs;
		qz = z_q >>> (FRAC_BITS - 4);
		qs = qz + Z_BITS'(128);
		if (qs[Z_BITS-1])
			lut_idx = 8'd0;
		else if (qs > Z_BITS'(255))
			lut_idx = 8'd255;
		else
			lut_idx = qs[7:0];
		if (relu_q) begin
			if (z_q[Z_BITS-1] || z_q == '0)
				act_val = '0;
			else if (z_q > Z_BITS'((2 ** (VALUE_BITS - 1)) - 1))
				act_val = VALUE_BITS'((2 ** (VALUE_BITS - 1)) - 1);
			else
				act_val = z_q[VALUE_BITS-1:0];
		end else begin
			act_val = VALUE_BITS'(SIG_LUT[lut_idx]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			lcount_q   <= 3'd2;
			win_q      <= CFG_DATA_BITS'(2);
			wout_q     <= '{CFG_DATA_BITS'(3), CFG_DATA_BITS'(1), CFG_DATA_BITS'(1),
				CFG_DATA_BITS'(1)};
			relu_q     <= 1'b0;
			layer_q    <= '0;
			row_q      <= '0;
			col_q      <= '0;
			bias_vld_q <= '0;
			in_q       <= '{default: '0};
			hid_q      <= '{default: '0};
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LAYER_COUNT: lcount_q <= cfg_data[2:0];
					REG_WIDTH_IN:    win_q    <= cfg_data;
					REG_ACT_MODE:    relu_q   <= cfg_data[0];
					default: begin
						if (cfg_index inside {[REG_WIDTH_FIRST:REG_WIDTH_LAST]})
							wout_q[LAYER_BITS'(cfg_index - REG_WIDTH_FIRST)] <= cfg_data;
					end
				endcase
			end
			if (b_we)
				bias_vld_q[b_addr] <= 1'b1;
			if (x_we)
				in_q[row_sel] <= value;
			case (state_q)
				S_IDLE: begin
					if (in_acc && action == ACT_START) begin
						layer_q <= '0;
						row_q   <= '0;
						state_q <= S_BIAS;
					end
				end
				S_BIAS: state_q <= S_BLD;
				S_BLD: begin
					col_q   <= '0;
					state_q <= S_RD;
				end
				S_RD:  state_q <= S_MUL;
				S_MUL: state_q <= S_ADD;
				S_ADD: begin
					if (col_end) begin
						state_q <= S_RND;
					end else begin
						col_q   <= col_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_RND: state_q <= S_ACT;
				S_ACT: begin
					if (row_end) begin
						state_q <= S_COPY;
					end else begin
						row_q   <= row_q + 1'b1;
						state_q <= S_BIAS;
					end
				end
				S_COPY: begin
					hid_q <= tmp_q;
					row_q <= '0;
					if (layer_end) begin
						state_q <= S_OUT;
					end else begin
						layer_q <= layer_q + 1'b1;
						state_q <= S_BIAS;
					end
				end
				S_OUT: begin
					if (out_acc) begin
						if (row_end)
							state_q <= S_IDLE;
						else
							row_q <= row_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// mac datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_BLD: begin
				if (bias_vld_q[b_addr])
					acc_q <= {{(ACC_BITS - VALUE_BITS - FRAC_BITS){b_rdata[VALUE_BITS-1]}},
						b_rdata, FRAC_BITS'(0)};
				else
					acc_q <= '0;
			end
			S_MUL: prod_q <= $signed(w_rdata) * x_sel;
			S_ADD: acc_q <= acc_q + {{(ACC_BITS - 2 * VALUE_BITS){prod_q[2*VALUE_BITS-1]}},
				prod_q};
			S_RND: z_q <= acc_rnd[ACC_BITS-1:FRAC_BITS];
			S_ACT: tmp_q[row_q] <= act_val;
			default: ;
		endcase
	end

	assign out_valid = (state_q == S_OUT);
	assign out_index = row_q;
	assign out_value = hid_q[row_q];
	assign out_last  = row_end;

endmodule

// ===== sv/mlpdl_ram.sv =====
// ----------------------------------------------------------------------------
// mlpdl_ram
// single-port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlpdl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/mlpdl_checker.sv =====
// ----------------------------------------------------------------------------
// mlpdl_checker
// port-level checks of the dense layer inference core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "mlp_dense_layer_inference_core_assert.svh"

module mlpdl_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    in_stall,
	input logic                                    out_valid,
	input logic                                    out_stall,
	input logic [mlpdl_pkg::ROW_BITS-1:0]          out_index,
	input logic signed [mlpdl_pkg::VALUE_BITS-1:0] out_value,
	input logic                                    out_last
);

	`MLPDL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_index) && $stable(out_value) && $stable(out_last), "stalled result changed")
	`MLPDL_ASSERT_SAME(a_busy_out, out_valid, in_stall, "input taken while results pending")
	`MLPDL_ASSERT_SAME(a_first_idx, $rose(out_valid), out_index == '0, "first result index not zero")
	`MLPDL_ASSERT_NEXT(a_idx_step, out_valid && !out_stall && !out_last, out_valid && out_index == $past(out_index) + 1'b1, "result index did not advance")

endmodule

bind mlp_dense_layer_inference_core mlpdl_checker u_mlpdl_checker (.*);
